### rtl/core/lir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and control/status types for the linear interpolation
// resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int DEF_MAX_UPSAMPLE = 16;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int FRAC_BITS = 24;
  localparam int PHASE_W   = 34;
  localparam int STEP_W    = 32;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << FRAC_BITS;

  // in_op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic load_cur;  // capture the new sample
    logic flush;     // restart phase at one
    logic calc;      // form one product, advance phase
    logic finalize;  // drop phase by one (clear it if below one), new sample becomes previous
  } lir_cmd_t;

  typedef struct packed {
    logic phase_lt_one;  // current phase below one
    logic sum_ge_one;    // phase plus step reaches one
  } lir_status_t;

endpackage

### rtl/core/linear_interp_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter, one input sample per
// transaction, zero or more interpolated samples out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_op selects a new sample (in_sample,
// signed Q1.15) or a flush, which restarts the phase at one and gives no
// output. Output channel (out_valid/out_ready): out_sample with out_last
// marking the final result caused by an input sample.
// cfg_wr_en/cfg_wr_data write step_ratio (UQ8.24, input rate / output rate);
// write it only while the block is idle.
// Timing: one input is handled at a time. A flush is done as it is accepted.
// A sample is accepted, then each output takes a multiply step (ST_CALC)
// and a presentation step (ST_EMIT); a sample with no outputs is finished
// in the multiply step. The product is registered before the rounding add,
// and the output is held from that register. At most MAX_UPSAMPLE outputs
// per input sample.
// A stalled receiver holds the block in its presentation cycle; no input is
// taken until every result of the current sample has been delivered.
// Reset: step_ratio = 1.0, phase = 1.0, previous sample = 0.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int MAX_UPSAMPLE = lir_pkg::DEF_MAX_UPSAMPLE,
  parameter int SAMPLE_BITS  = lir_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);
  import lir_pkg::*;

  lir_cmd_t    cmd;
  lir_status_t status;

  lir_ctrl #(
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_last (out_last),
    .cmd      (cmd),
    .status   (status)
  );

  lir_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_sample  (in_sample),
    .out_sample (out_sample),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

### rtl/core/lir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer: accepts items, steps the interpolation loop and hands each
// result to the output channel.
// ----------------------------------------------------------------------------
module lir_ctrl #(
  parameter int MAX_UPSAMPLE = lir_pkg::DEF_MAX_UPSAMPLE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  output lir_pkg::lir_cmd_t    cmd,
  input  lir_pkg::lir_status_t status
);
  import lir_pkg::*;

  localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [CNT_W-1:0] CNT_FINAL = CNT_W'(MAX_UPSAMPLE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_last  = last_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_FLUSH) begin
            cmd.flush = 1'b1;
          end else begin
            cmd.load_cur = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (!status.phase_lt_one) begin
          // no output point before the new sample
          cmd.finalize = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.calc  = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          last_nxt  = status.sum_ge_one || (cnt_r == CNT_FINAL);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (last_r) begin
            cmd.finalize = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

### rtl/core/lir_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_datapath
// Sample registers, phase accumulator, step register and the interpolation
// multiplier with rounding.
// ----------------------------------------------------------------------------
module lir_datapath #(
  parameter int SAMPLE_BITS = lir_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wr_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  input  lir_pkg::lir_cmd_t             cmd,
  output lir_pkg::lir_status_t          status
);
  import lir_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int FRAC_W = FRAC_BITS + 1;  // fraction with a zero sign bit
  localparam int PROD_W = DIFF_W + FRAC_W;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

  logic [STEP_W-1:0]              step_r;
  logic [PHASE_W-1:0]             phase_r, phase_nxt;
  logic signed [SAMPLE_BITS-1:0]  prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0]  cur_r;
  logic signed [PROD_W-1:0]       prod_r;

  logic [PHASE_W-1:0]             phase_sum;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [FRAC_W-1:0]       frac;
  logic signed [PROD_W-1:0]       prod;
  logic signed [PROD_W-1:0]       rounded;

  assign phase_sum = phase_r + PHASE_W'(step_r);
  assign status.phase_lt_one = ~|phase_r[PHASE_W-1:FRAC_BITS];
  assign status.sum_ge_one   = |phase_sum[PHASE_W-1:FRAC_BITS];

  // prev*(1-f) + cur*f = prev + (cur-prev)*f
  assign diff = DIFF_W'(cur_r) - DIFF_W'(prev_r);
  assign frac = {1'b0, phase_r[FRAC_BITS-1:0]};
  assign prod = PROD_W'(diff) * PROD_W'(frac);

  assign rounded    = prod_r + HALF_LSB;
  assign out_sample = prev_r + rounded[FRAC_BITS +: SAMPLE_BITS];

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    if (cmd.flush) begin
      phase_nxt = PHASE_ONE;
    end else if (cmd.calc) begin
      phase_nxt = phase_sum;
    end else if (cmd.finalize) begin
      // a loop cut short by the output limit leaves the phase at zero
      phase_nxt = status.phase_lt_one ? '0 : phase_r - PHASE_ONE;
      prev_nxt  = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RESET;
      phase_r <= PHASE_ONE;
      prev_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur_r <= in_sample;
    end
    if (cmd.calc) begin
      prod_r <= prod;
    end
  end

endmodule
